/* sv/edit_list_trimmer_macros.svh */
`ifndef EDIT_LIST_TRIMMER_MACROS_SVH
`define EDIT_LIST_TRIMMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ELT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, checked outside reset
`define ELT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* sv/elt_pkg.sv */
package elt_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned TypeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResCntW  = 2;
  // result queue depth, a power of two holding at least MaxRes results
  localparam int unsigned ResQDepth = 4;
  localparam int unsigned ResQPtrW  = $clog2(ResQDepth);
  localparam int unsigned ResQCntW  = ResQPtrW + 1;

  localparam logic [TimeW-1:0] EmptyMark = '1;
  localparam logic [TimeW-1:0] SignedMax = {1'b0, {(TimeW-1){1'b1}}};

  typedef enum logic [1:0] {
    KIND_ENTRY    = 2'd0,
    KIND_END      = 2'd1,
    KIND_INVALID  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_DONE   = 2'd2,
    PH_FAILED = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIM_START    = 2'd0,
    CFG_TRIM_DURATION = 2'd1,
    CFG_TRACK_TYPE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] trim_start;
    logic [TimeW-1:0] trim_duration;
    logic [TypeW-1:0] track_type;
  } cfg_t;

  typedef struct packed {
    logic signed [TimeW-1:0] box_start;
    logic [TimeW-1:0]        box_duration;
    logic [TypeW-1:0]        box_type;
    logic                    is_last;
    logic                    list_empty;
  } item_t;

  typedef struct packed {
    phase_e           phase;
    logic [TimeW-1:0] skip_left;
    logic [TimeW-1:0] budget_left;
  } st_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [TimeW-1:0] start;
    logic [TimeW-1:0]        duration;
    logic                    last;
  } res_t;

  // results of one item, r[0] first; n is the count
  typedef struct packed {
    logic [ResCntW-1:0]     n;
    res_t [MaxRes-1:0]      r;
  } step_t;

endpackage

/* sv/elt_if.sv */
interface elt_in_if;
  import elt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [TimeW-1:0] box_start;
  logic [TimeW-1:0]        box_duration;
  logic [TypeW-1:0]        box_type;
  logic                    is_last;
  logic                    list_empty;

  modport source (output valid, box_start, box_duration, box_type, is_last, list_empty,
                  input ready);
  modport sink (input valid, box_start, box_duration, box_type, is_last, list_empty,
                output ready);
endinterface

interface elt_out_if;
  import elt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              out_kind;
  logic signed [TimeW-1:0] out_start;
  logic [TimeW-1:0]        out_duration;
  logic                    out_last;

  modport source (output valid, out_kind, out_start, out_duration, out_last, input ready);
  modport sink (input valid, out_kind, out_start, out_duration, out_last, output ready);
endinterface

interface elt_cfg_if;
  import elt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/edit_list_trimmer.sv */
// datapath: an item is taken into the input register; once the result queue has room
//   for all of its results they are written into it, and the queue head drives the output
// throughput: one item per cycle while items give at most one result each and the output
//   is not stalled; an item gives up to three results, which leave the 4-entry result queue
//   one per output transfer; reset: asynchronous, clears the queues, the config registers
//   to zero and the list state to first entry expected
module edit_list_trimmer (
  input logic    clk_i,
  input logic    rst_ni,
  elt_cfg_if.sink   cfg_i,
  elt_in_if.sink    in_i,
  elt_out_if.source out_o
);
  import elt_pkg::*;

  // config registers
  cfg_t  cfg_q;

  // input register
  logic  inq_valid_q;
  item_t inq_q;
  item_t in_item;

  // list state
  st_t   st_q;
  st_t   st_d;

  step_t step;
  step_t push;
  res_t  head;

  logic [ResQCntW-1:0] rq_count;
  logic [ResQCntW-1:0] rq_free;
  logic                process;
  logic                in_xfer;
  logic                out_xfer;

  // config writes are to be made only while the block is idle; the block does not enforce this, no hazard check
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_TRIM_START:    cfg_q.trim_start    <= cfg_i.data;
        CFG_TRIM_DURATION: cfg_q.trim_duration <= cfg_i.data;
        CFG_TRACK_TYPE:    cfg_q.track_type    <= cfg_i.data[TypeW-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_item.box_start    = in_i.box_start;
  assign in_item.box_duration = in_i.box_duration;
  assign in_item.box_type     = in_i.box_type;
  assign in_item.is_last      = in_i.is_last;
  assign in_item.list_empty   = in_i.list_empty;

  // the held item moves on once the queue has room for all of its results;
  // only registered state feeds this, so ready never waits on the output side
  assign rq_free    = ResQCntW'(ResQDepth) - rq_count;
  assign process    = inq_valid_q && (rq_free >= ResQCntW'(step.n));
  assign in_i.ready = !inq_valid_q || process;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_xfer) begin
      inq_valid_q <= 1'b1;
    end else if (process) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) inq_q <= in_item;
  end

  // one pass over the held item: results and next list state
  elt_step u_step (
    .cfg_i  (cfg_q),
    .item_i (inq_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .step_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PH_FIRST;
      st_q.skip_left   <= '0;
      st_q.budget_left <= '0;
    end else if (process) begin
      st_q <= st_d;
    end
  end

  // nothing goes into the queue unless the item really moves on
  always_comb begin
    push = step;
    if (!process) push.n = '0;
  end

  // result queue, also the output register
  elt_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_xfer),
    .head_o  (head),
    .count_o (rq_count)
  );

  assign out_o.valid        = (rq_count != '0);
  assign out_o.out_kind     = head.kind;
  assign out_o.out_start    = head.start;
  assign out_o.out_duration = head.duration;
  assign out_o.out_last     = head.last;
  assign out_xfer           = out_o.valid && out_o.ready;

endmodule

/* sv/elt_step.sv */
module elt_step (
  input  elt_pkg::cfg_t  cfg_i,
  input  elt_pkg::item_t item_i,
  input  elt_pkg::st_t   st_i,
  output elt_pkg::st_t   st_o,
  output elt_pkg::step_t step_o
);
  import elt_pkg::*;

  function automatic res_t mk_res(kind_e kind, logic [TimeW-1:0] start,
                                  logic [TimeW-1:0] duration, logic last);
    res_t r;
    r.kind     = kind;
    r.start    = $signed(start);
    r.duration = duration;
    r.last     = last;
    return r;
  endfunction

  logic             empty_edit;
  logic             last;
  logic [TimeW-1:0] bdur;

  // leading empty edit
  logic             ee_s_ge;
  logic [TimeW:0]   ee_win_end;
  logic             ee_swallow;
  logic [TimeW-1:0] ee_gap;
  logic [TimeW-1:0] ee_s;
  logic [TimeW-1:0] ee_off;
  logic [TimeW-1:0] ee_d;

  // real entry against running offset and budget
  logic [TimeW-1:0] sk;
  logic [TimeW-1:0] bg;
  logic             a_bad;
  logic             a_consume;
  logic [TimeW-1:0] a_sum;
  logic             a_ovf;
  logic [TimeW-1:0] a_avail;
  logic [TimeW-1:0] a_od;
  logic [TimeW-1:0] a_bg_left;

  assign empty_edit = ($unsigned(item_i.box_start) == EmptyMark);
  assign last       = item_i.is_last;
  assign bdur       = item_i.box_duration;

  assign ee_s_ge    = (cfg_i.trim_start >= bdur);
  assign ee_win_end = {1'b0, cfg_i.trim_start} + {1'b0, cfg_i.trim_duration};
  assign ee_swallow = !ee_s_ge && (ee_win_end <= {1'b0, bdur});
  assign ee_gap     = bdur - cfg_i.trim_start;
  assign ee_s       = ee_s_ge ? (cfg_i.trim_start - bdur) : '0;
  assign ee_off     = ee_s_ge ? '0 : ee_gap;
  assign ee_d       = ee_s_ge ? cfg_i.trim_duration : (cfg_i.trim_duration - ee_gap);

  assign sk        = (st_i.phase == PH_FIRST) ? cfg_i.trim_start : st_i.skip_left;
  assign bg        = (st_i.phase == PH_FIRST) ? cfg_i.trim_duration : st_i.budget_left;
  assign a_bad     = (item_i.box_type != cfg_i.track_type) || empty_edit;
  assign a_consume = (sk >= bdur);
  assign a_sum     = $unsigned(item_i.box_start) + sk;
  assign a_ovf     = a_sum[TimeW-1];
  assign a_avail   = bdur - sk;
  assign a_od      = (a_avail < bg) ? a_avail : bg;
  assign a_bg_left = bg - a_od;

  // next state
  always_comb begin
    st_o = st_i;
    if (!item_i.list_empty) begin
      if (st_i.phase == PH_FIRST && empty_edit) begin
        if (ee_swallow) begin
          st_o.phase = last ? PH_FIRST : PH_DONE;
        end else if (!last) begin
          st_o.skip_left   = ee_s;
          st_o.budget_left = ee_d;
          st_o.phase       = PH_ACTIVE;
        end
      end else begin
        unique case (st_i.phase) inside
          PH_FIRST, PH_ACTIVE: begin
            st_o.skip_left   = sk;
            st_o.budget_left = bg;
            st_o.phase       = PH_ACTIVE;
            if (a_bad) begin
              st_o.phase = PH_FAILED;
            end else if (a_consume) begin
              st_o.skip_left = sk - bdur;
            end else if (a_ovf) begin
              st_o.phase = PH_FAILED;
            end else begin
              st_o.skip_left   = '0;
              st_o.budget_left = a_bg_left;
              st_o.phase       = (a_bg_left == '0) ? PH_DONE : PH_ACTIVE;
            end
          end
          PH_DONE: begin
            if (empty_edit) st_o.phase = PH_FAILED;
          end
          default: ;
        endcase
        if (last) st_o.phase = PH_FIRST;
      end
    end
  end

  // results
  always_comb begin
    step_o = '0;
    if (item_i.list_empty) begin
      if (st_i.phase == PH_FIRST) begin
        step_o.r[0] = (cfg_i.trim_start > SignedMax)
                    ? mk_res(KIND_OVERFLOW, '0, '0, 1'b0)
                    : mk_res(KIND_ENTRY, cfg_i.trim_start, cfg_i.trim_duration, 1'b0);
        step_o.r[1] = mk_res(KIND_END, '0, '0, 1'b1);
        step_o.n    = ResCntW'(2);
      end
    end else if (st_i.phase == PH_FIRST && empty_edit) begin
      if (ee_swallow) begin
        if (last) begin
          step_o.r[0] = mk_res(KIND_END, '0, '0, 1'b1);
          step_o.n    = ResCntW'(1);
        end
      end else if (last && ee_s[TimeW-1]) begin
        step_o.r[0] = mk_res(KIND_OVERFLOW, '0, '0, 1'b0);
        step_o.r[1] = mk_res(KIND_END, '0, '0, 1'b1);
        step_o.n    = ResCntW'(2);
      end else begin
        if (ee_off != '0) begin
          step_o.r[step_o.n] = mk_res(KIND_ENTRY, EmptyMark, ee_off, 1'b0);
          step_o.n           = step_o.n + ResCntW'(1);
        end
        if (last) begin
          step_o.r[step_o.n] = mk_res(KIND_ENTRY, ee_s, ee_d, 1'b0);
          step_o.n           = step_o.n + ResCntW'(1);
          step_o.r[step_o.n] = mk_res(KIND_END, '0, '0, 1'b1);
          step_o.n           = step_o.n + ResCntW'(1);
        end
      end
    end else begin
      unique case (st_i.phase) inside
        PH_FIRST, PH_ACTIVE: begin
          if (a_bad) begin
            step_o.r[0] = mk_res(KIND_INVALID, '0, '0, 1'b0);
            step_o.n    = ResCntW'(1);
          end else if (!a_consume) begin
            step_o.r[0] = a_ovf ? mk_res(KIND_OVERFLOW, '0, '0, 1'b0)
                                : mk_res(KIND_ENTRY, a_sum, a_od, 1'b0);
            step_o.n    = ResCntW'(1);
          end
        end
        PH_DONE: begin
          if (empty_edit) begin
            step_o.r[0] = mk_res(KIND_INVALID, '0, '0, 1'b0);
            step_o.n    = ResCntW'(1);
          end
        end
        default: ;
      endcase
      if (last) begin
        step_o.r[step_o.n] = mk_res(KIND_END, '0, '0, 1'b1);
        step_o.n           = step_o.n + ResCntW'(1);
      end
    end
  end

endmodule

/* sv/elt_rq.sv */
module elt_rq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  elt_pkg::step_t              push_i,
  input  logic                        pop_i,
  output elt_pkg::res_t               head_o,
  output logic [elt_pkg::ResQCntW-1:0] count_o
);
  import elt_pkg::*;

  res_t                mem_q [ResQDepth];
  logic [ResQPtrW-1:0] wr_ptr_q;
  logic [ResQPtrW-1:0] wr_ptr_d;
  logic [ResQPtrW-1:0] rd_ptr_q;
  logic [ResQPtrW-1:0] rd_ptr_d;
  logic [ResQCntW-1:0] count_q;
  logic [ResQCntW-1:0] count_d;

  assign wr_ptr_d = wr_ptr_q + ResQPtrW'(push_i.n);
  assign rd_ptr_d = rd_ptr_q + ResQPtrW'(pop_i);
  assign count_d  = count_q + ResQCntW'(push_i.n) - ResQCntW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // each slot takes the result whose place after the write pointer it holds
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < ResQDepth; e++) begin
      logic [ResQPtrW-1:0] off;
      off = ResQPtrW'(e) - wr_ptr_q;
      if (ResQCntW'(off) < ResQCntW'(push_i.n)) begin
        mem_q[e] <= push_i.r[off[ResCntW-1:0]];
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* sv/elt_checker.sv */
module elt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  out_kind_i,
  input logic [elt_pkg::TimeW-1:0]   out_start_i,
  input logic [elt_pkg::TimeW-1:0]   out_duration_i,
  input logic                        out_last_i
);
  `include "edit_list_trimmer_macros.svh"

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // a stalled result stays put
  `ELT_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_start_i) && $stable(out_duration_i) && $stable(out_last_i))

  // input only backs up behind waiting results
  `ELT_ASSERT_IMP(a_in_stall, !in_ready_i, out_valid_i)

  // nothing queued right after reset
  `ELT_ASSERT_IMP(a_reset_empty, $rose(rst_ni), !out_valid_i)

  // no result without an item behind it
  `ELT_ASSERT_NXT(a_no_phantom, !in_xfer && !out_valid_i && $past(!in_xfer) && $past(!out_valid_i), !out_valid_i)

endmodule

bind edit_list_trimmer elt_checker u_elt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.out_kind),
  .out_start_i    (out_o.out_start),
  .out_duration_i (out_o.out_duration),
  .out_last_i     (out_o.out_last)
);
